// ===== rtl/msdf_pkg.sv =====
// ============================================================================
// msdf_pkg - shared types and constants of the stream deframer
// Header layout, status and kind codes, config register indexes, the result
// transaction struct and the bytewise CRC32 update.
// ============================================================================
package msdf_pkg;

    // Header layout (big-endian fields)
    localparam int HEADER_BYTES = 16;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
    localparam int CRC_SPAN     = 12;
    localparam int HDR_MAGIC    = 0;
    localparam int HDR_LEN      = 4;
    localparam int HDR_SID      = 8;
    localparam int HDR_TYPE     = 10;
    localparam int HDR_CRC      = 12;

    // Frame types
    localparam logic [7:0] TYPE_DATA = 8'd0;
    localparam logic [7:0] TYPE_EOF  = 8'd1;

    // CRC32 (reflected)
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Stream table size and config reset values
    localparam int          STREAM_COUNT_DEF  = 4;
    localparam logic [31:0] MAGIC_WORD_RST    = 32'h4653_5231;
    localparam logic [31:0] SEQ_LIMIT_RST     = 32'd2000;
    localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd4096;

    // Config register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  CFG_MAGIC_WORD  = 2'd0;
    localparam logic [1:0]  CFG_SEQ_LIMIT   = 2'd1;
    localparam logic [1:0]  CFG_MAX_PAYLOAD = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_MAGIC_ERR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_DATA_OK    = 3'd0,
        ST_EOF        = 3'd1,
        ST_CRC_ERR    = 3'd2,
        ST_BAD_STREAM = 3'd3,
        ST_BAD_TYPE   = 3'd4,
        ST_SEQ_OVF    = 3'd5,
        ST_OVERSIZE   = 3'd6
    } t_status;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] stream_id;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [2:0]  status;
        logic [31:0] seq_number;
        logic [15:0] eof_total;
    } t_out_item;

    // CRC32 update by one byte, eight shift steps
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        int          k;
        r = c ^ {24'd0, b};
        for (k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/msdf_if.sv =====
// ============================================================================
// msdf_if - channel interfaces of the stream deframer
// Link byte input, result output and config write channel, each a
// valid/ready handshake with source and sink modports.
// ============================================================================

// Link byte channel
interface msdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Result channel
interface msdf_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] stream_id;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [2:0]  status;
    logic [31:0] seq_number;
    logic [15:0] eof_total;

    modport source (output valid, output kind, output stream_id, output payload_byte,
                    output frame_last, output status, output seq_number,
                    output eof_total, input ready);
    modport sink   (input valid, input kind, input stream_id, input payload_byte,
                    input frame_last, input status, input seq_number,
                    input eof_total, output ready);
endinterface

// Config write channel
interface msdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/msdf_out_buf.sv =====
// ============================================================================
// msdf_out_buf - two-entry result buffer
// Output register plus skid entry. Upstream ready is registered, so the
// input side never waits combinationally on the downstream ready.
// ============================================================================
module msdf_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  msdf_pkg::t_out_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output msdf_pkg::t_out_item o_item
);

    logic                r_main_v;
    logic                r_skid_v;
    msdf_pkg::t_out_item r_main;
    msdf_pkg::t_out_item r_skid;
    logic                pop;

    assign pop     = r_main_v & i_ready;
    assign o_ready = ~r_skid_v;
    assign o_valid = r_main_v;
    assign o_item  = r_main;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_valid;
            end
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            r_main <= r_skid_v ? r_skid : i_item;
        end else if (i_valid && !r_skid_v) begin
            r_skid <= i_item;
        end
    end

endmodule

// ===== rtl/muxed_stream_deframer_crc32_header_core.sv =====
// ============================================================================
// muxed_stream_deframer_crc32_header_core - length-prefixed frame deframer
// Parses 16-byte CRC32-protected headers from a byte stream, forwards payload
// of good data frames and reports per-frame status with per-stream counters.
// ============================================================================
//
//  channel  dir  handshake      transaction
//  -------  ---  -------------  ----------------------------------------------
//  i_in     in   valid/ready    one link byte (data_byte)
//  o_out    out  valid/ready    one result: kind, stream id, byte, status, ...
//  i_cfg    in   valid/ready    register write: index, data (ready always 1)
//
//  One link byte per cycle; each byte is processed in the cycle it is taken
//  and its result, if any, is registered in the output register or skid entry.
//  The per-stream counter table is read once per frame on header byte 9 and
//  written back on the final result of a frame without a CRC, stream or type
//  error. Reset clears the table's valid bits at once, so no clearing pass is
//  needed. Input stalls only when the two-entry result buffer is full. After a
//  magic error, input is taken and dropped until reset.
//
module muxed_stream_deframer_crc32_header_core #(
    parameter int STREAM_COUNT = msdf_pkg::STREAM_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msdf_byte_if.sink     i_in,
    msdf_result_if.source o_out,
    msdf_cfg_if.sink      i_cfg
);

    localparam int SID_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
    localparam logic [16:0] SID_LIMIT = 17'(STREAM_COUNT);
    localparam int HC_W = msdf_pkg::HDR_CNT_W;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] eof;
    } t_ctr;

    // Config registers
    logic [31:0] r_magic_word;
    logic [31:0] r_seq_limit;
    logic [15:0] r_max_payload;

    // Frame state
    t_phase            r_phase,   n_phase;
    logic [HC_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [31:0]       r_crc,     n_crc;
    logic [31:0]       r_left,    n_left;
    msdf_pkg::t_status r_verdict, n_verdict;
    logic [7:0]        r_hdr [msdf_pkg::HEADER_BYTES];

    // Per-stream counter table
    t_ctr              r_ctr_mem [STREAM_COUNT];
    logic              r_ctr_vld [STREAM_COUNT];
    t_ctr              r_rd;
    logic              r_rd_vld;
    logic [SID_W-1:0]  r_cur_idx;

    logic                in_fire;
    logic                buf_ready;
    logic [7:0]          b;
    logic [15:0]         hdr_sid;
    logic [31:0]         hdr_magic;
    logic [31:0]         hdr_len;
    logic [7:0]          hdr_type;
    logic [31:0]         hdr_crc;
    logic                crc_ok;
    logic                sid_ok;
    logic                rd_en;
    logic [SID_W-1:0]    rd_idx;
    t_ctr                cur;
    msdf_pkg::t_status   hdr_verdict;
    msdf_pkg::t_status   e_verdict;
    logic                emit_en;
    logic                emit_last;
    msdf_pkg::t_kind     emit_kind;
    logic [7:0]          emit_byte;
    logic                halt_res;
    logic                res_valid;
    msdf_pkg::t_out_item res_item;
    logic                wr_en;
    t_ctr                wr_data;
    msdf_pkg::t_out_item out_item;

    assign in_fire    = i_in.valid & i_in.ready;
    assign i_in.ready = buf_ready;
    assign b          = i_in.data_byte;
    assign i_cfg.ready = 1'b1;

    // Header fields; byte 15 is the byte on the input
    assign hdr_sid   = {r_hdr[msdf_pkg::HDR_SID], r_hdr[msdf_pkg::HDR_SID+1]};
    assign hdr_magic = {r_hdr[msdf_pkg::HDR_MAGIC], r_hdr[msdf_pkg::HDR_MAGIC+1],
                        r_hdr[msdf_pkg::HDR_MAGIC+2], r_hdr[msdf_pkg::HDR_MAGIC+3]};
    assign hdr_len   = {r_hdr[msdf_pkg::HDR_LEN], r_hdr[msdf_pkg::HDR_LEN+1],
                        r_hdr[msdf_pkg::HDR_LEN+2], r_hdr[msdf_pkg::HDR_LEN+3]};
    assign hdr_type  = r_hdr[msdf_pkg::HDR_TYPE];
    assign hdr_crc   = {r_hdr[msdf_pkg::HDR_CRC], r_hdr[msdf_pkg::HDR_CRC+1],
                        r_hdr[msdf_pkg::HDR_CRC+2], b};
    assign crc_ok    = (r_crc ^ msdf_pkg::CRC_ONES) == hdr_crc;
    assign sid_ok    = {1'b0, hdr_sid} < SID_LIMIT;

    // Counters of the current stream; unwritten entries read as zero
    assign cur = r_rd_vld ? r_rd : '0;

    // Header checks in priority order
    always_comb begin
        if (!crc_ok) begin
            hdr_verdict = msdf_pkg::ST_CRC_ERR;
        end else if (!sid_ok) begin
            hdr_verdict = msdf_pkg::ST_BAD_STREAM;
        end else if (hdr_type == msdf_pkg::TYPE_EOF) begin
            hdr_verdict = msdf_pkg::ST_EOF;
        end else if (hdr_type != msdf_pkg::TYPE_DATA) begin
            hdr_verdict = msdf_pkg::ST_BAD_TYPE;
        end else if (hdr_len > {16'd0, r_max_payload}) begin
            hdr_verdict = msdf_pkg::ST_OVERSIZE;
        end else if (cur.seq >= r_seq_limit) begin
            hdr_verdict = msdf_pkg::ST_SEQ_OVF;
        end else begin
            hdr_verdict = msdf_pkg::ST_DATA_OK;
        end
    end

    // Per-byte step
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_crc     = r_crc;
        n_left    = r_left;
        n_verdict = r_verdict;
        e_verdict = r_verdict;
        emit_en   = 1'b0;
        emit_last = 1'b0;
        emit_kind = msdf_pkg::KIND_FRAME_END;
        emit_byte = 8'd0;
        halt_res  = 1'b0;
        rd_en     = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                if (in_fire) begin
                    if (r_hdr_cnt < HC_W'(msdf_pkg::CRC_SPAN)) begin
                        n_crc = msdf_pkg::crc32_byte(r_crc, b);
                    end
                    rd_en     = r_hdr_cnt == HC_W'(msdf_pkg::HDR_SID + 1);
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                    if (r_hdr_cnt == HC_W'(msdf_pkg::HEADER_BYTES - 1)) begin
                        n_hdr_cnt = '0;
                        n_crc     = msdf_pkg::CRC_ONES;
                        if (hdr_magic != r_magic_word) begin
                            n_phase  = PH_HALT;
                            halt_res = 1'b1;
                        end else begin
                            n_verdict = hdr_verdict;
                            e_verdict = hdr_verdict;
                            n_left    = hdr_len;
                            if (hdr_len == 32'd0) begin
                                emit_en   = 1'b1;
                                emit_last = 1'b1;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (in_fire) begin
                    n_left    = r_left - 32'd1;
                    emit_last = r_left == 32'd1;
                    if (emit_last) begin
                        n_phase = PH_HEADER;
                    end
                    if (r_verdict == msdf_pkg::ST_DATA_OK) begin
                        emit_en   = 1'b1;
                        emit_kind = msdf_pkg::KIND_PAYLOAD;
                        emit_byte = b;
                    end else begin
                        emit_en = emit_last;
                    end
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    // Result and counter write-back
    always_comb begin
        res_item.kind         = emit_kind;
        res_item.stream_id    = hdr_sid;
        res_item.payload_byte = emit_byte;
        res_item.frame_last   = emit_last;
        res_item.status       = e_verdict;
        res_item.seq_number   = 32'd0;
        res_item.eof_total    = 16'd0;
        if (e_verdict != msdf_pkg::ST_CRC_ERR && e_verdict != msdf_pkg::ST_BAD_STREAM
            && sid_ok) begin
            res_item.seq_number = cur.seq;
            res_item.eof_total  = cur.eof;
            if (e_verdict == msdf_pkg::ST_EOF && cur.eof != 16'hFFFF) begin
                res_item.eof_total = cur.eof + 16'd1;
            end
        end
        if (halt_res) begin
            res_item.kind         = msdf_pkg::KIND_MAGIC_ERR;
            res_item.payload_byte = 8'd0;
            res_item.frame_last   = 1'b1;
            res_item.status       = msdf_pkg::ST_DATA_OK;
            res_item.seq_number   = 32'd0;
            res_item.eof_total    = 16'd0;
        end
        res_valid = emit_en | halt_res;

        wr_data = cur;
        wr_en   = 1'b0;
        if (emit_en && emit_last && sid_ok) begin
            case (e_verdict)
                msdf_pkg::ST_DATA_OK, msdf_pkg::ST_SEQ_OVF, msdf_pkg::ST_OVERSIZE: begin
                    wr_en = 1'b1;
                    if (cur.seq != 32'hFFFF_FFFF) begin
                        wr_data.seq = cur.seq + 32'd1;
                    end
                end
                msdf_pkg::ST_EOF: begin
                    wr_en = 1'b1;
                    if (cur.eof != 16'hFFFF) begin
                        wr_data.eof = cur.eof + 16'd1;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign rd_idx = SID_W'({r_hdr[msdf_pkg::HDR_SID], b});

    // Frame state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_hdr_cnt     <= '0;
            r_crc         <= msdf_pkg::CRC_ONES;
            r_left        <= 32'd0;
            r_verdict     <= msdf_pkg::ST_DATA_OK;
            r_magic_word  <= msdf_pkg::MAGIC_WORD_RST;
            r_seq_limit   <= msdf_pkg::SEQ_LIMIT_RST;
            r_max_payload <= msdf_pkg::MAX_PAYLOAD_RST;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_crc     <= n_crc;
            r_left    <= n_left;
            r_verdict <= n_verdict;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    msdf_pkg::CFG_MAGIC_WORD:  r_magic_word  <= i_cfg.data;
                    msdf_pkg::CFG_SEQ_LIMIT:   r_seq_limit   <= i_cfg.data;
                    msdf_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg.data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Header byte store
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_HEADER && in_fire) begin
            r_hdr[r_hdr_cnt] <= b;
        end
    end

    // Counter table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STREAM_COUNT; s++) begin
                r_ctr_vld[s] <= 1'b0;
            end
        end else if (wr_en) begin
            r_ctr_vld[r_cur_idx] <= 1'b1;
        end
    end

    // Counter table: one read per frame, at most one write at frame end
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ctr_mem[r_cur_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd      <= r_ctr_mem[rd_idx];
            r_rd_vld  <= r_ctr_vld[rd_idx];
            r_cur_idx <= rd_idx;
        end
    end

    msdf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (buf_ready),
        .i_item  (res_item),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (out_item)
    );

    assign o_out.kind         = out_item.kind;
    assign o_out.stream_id    = out_item.stream_id;
    assign o_out.payload_byte = out_item.payload_byte;
    assign o_out.frame_last   = out_item.frame_last;
    assign o_out.status       = out_item.status;
    assign o_out.seq_number   = out_item.seq_number;
    assign o_out.eof_total    = out_item.eof_total;

    // Halt after a magic error lasts until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("deframer left halt without reset");

    // Header byte count runs only while collecting a header
    a_hdr_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_hdr_cnt == '0)
        else $error("header count nonzero outside header phase");

    // Payload phase always has bytes left
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != 32'd0)
        else $error("payload phase with zero bytes left");

    // Only payload results may leave a frame open
    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.kind != msdf_pkg::KIND_PAYLOAD |-> o_out.frame_last)
        else $error("frame end result without last flag");

endmodule

// ===== bench/msdf_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// msdf_checker - result predictor and scoreboard of the stream deframer
// Watches the link byte, result and config channels. Every accepted link
// byte runs through a cycle-free model of the deframer that queues the result
// transactions it causes; every accepted result is compared field by field
// with the oldest queued one. Mismatches are counted for the top level.
// ============================================================================
module msdf_checker #(
    parameter int STREAMS = msdf_pkg::STREAM_COUNT_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    msdf_byte_if   in_ch,
    msdf_result_if out_ch,
    msdf_cfg_if    cfg_ch,
    output int     o_fail_count,
    output int     o_pending
);
    import msdf_pkg::*;

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_PAYLOAD,
        PARSE_HALTED
    } t_parse;

    // Model state
    t_parse      parse_state;
    int unsigned hdr_fill;
    logic [7:0]  hdr_bytes [HEADER_BYTES];
    logic [31:0] crc_acc;
    logic [31:0] bytes_left;
    t_status     verdict;
    logic [31:0] seq_tab [STREAMS];
    logic [15:0] eof_tab [STREAMS];

    // Shadow copy of the config registers
    logic [31:0] magic_reg;
    logic [31:0] seq_limit_reg;
    logic [15:0] max_len_reg;

    t_out_item   expected_q [$];
    int          fail_count;

    // Reflected CRC32, one byte, mask form
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        return r;
    endfunction

    function automatic logic [31:0] hdr_word(input int at);
        return {hdr_bytes[at], hdr_bytes[at + 1], hdr_bytes[at + 2], hdr_bytes[at + 3]};
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Queue one frame result and move the stream counters on the final one
    task automatic push_frame_result(input t_kind kind, input logic [7:0] b, input logic last);
        t_out_item   exp;
        logic [15:0] sid;
        sid              = {hdr_bytes[HDR_SID], hdr_bytes[HDR_SID + 1]};
        exp.kind         = kind;
        exp.stream_id    = sid;
        exp.payload_byte = b;
        exp.frame_last   = last;
        exp.status       = verdict;
        exp.seq_number   = '0;
        exp.eof_total    = '0;
        if (verdict != ST_CRC_ERR && verdict != ST_BAD_STREAM && sid < STREAMS) begin
            exp.seq_number = seq_tab[sid];
            exp.eof_total  = eof_tab[sid];
            if (verdict == ST_EOF && eof_tab[sid] != 16'hFFFF) begin
                exp.eof_total = eof_tab[sid] + 16'd1;
            end
        end
        expected_q.push_back(exp);
        if (last && sid < STREAMS) begin
            if (verdict == ST_DATA_OK || verdict == ST_SEQ_OVF || verdict == ST_OVERSIZE) begin
                if (seq_tab[sid] != 32'hFFFF_FFFF) seq_tab[sid] = seq_tab[sid] + 32'd1;
            end else if (verdict == ST_EOF) begin
                if (eof_tab[sid] != 16'hFFFF) eof_tab[sid] = eof_tab[sid] + 16'd1;
            end
        end
    endtask

    // One link byte through the deframer model
    task automatic take_byte(input logic [7:0] b);
        t_out_item   halt_res;
        logic [15:0] sid;
        logic [7:0]  ftype;
        logic [31:0] plen;
        logic        crc_good;
        logic        last;
        case (parse_state)
            PARSE_HEADER: begin
                hdr_bytes[hdr_fill] = b;
                if (hdr_fill < CRC_SPAN) crc_acc = crc_step(crc_acc, b);
                hdr_fill++;
                if (hdr_fill == HEADER_BYTES) begin
                    hdr_fill = 0;
                    crc_good = (crc_acc ^ CRC_ONES) == hdr_word(HDR_CRC);
                    crc_acc  = CRC_ONES;
                    sid      = {hdr_bytes[HDR_SID], hdr_bytes[HDR_SID + 1]};
                    ftype    = hdr_bytes[HDR_TYPE];
                    plen     = hdr_word(HDR_LEN);
                    if (hdr_word(HDR_MAGIC) != magic_reg) begin
                        // bad start word: single halt result, then deaf until reset
                        parse_state           = PARSE_HALTED;
                        halt_res              = '0;
                        halt_res.kind         = KIND_MAGIC_ERR;
                        halt_res.stream_id    = sid;
                        halt_res.frame_last   = 1'b1;
                        halt_res.status       = ST_DATA_OK;
                        expected_q.push_back(halt_res);
                    end else begin
                        if (!crc_good) verdict = ST_CRC_ERR;
                        else if (sid >= STREAMS) verdict = ST_BAD_STREAM;
                        else if (ftype == TYPE_EOF) verdict = ST_EOF;
                        else if (ftype != TYPE_DATA) verdict = ST_BAD_TYPE;
                        else if (plen > {16'd0, max_len_reg}) verdict = ST_OVERSIZE;
                        else if (seq_tab[sid] >= seq_limit_reg) verdict = ST_SEQ_OVF;
                        else verdict = ST_DATA_OK;
                        bytes_left = plen;
                        if (plen == 32'd0) begin
                            push_frame_result(KIND_FRAME_END, 8'd0, 1'b1);
                        end else begin
                            parse_state = PARSE_PAYLOAD;
                        end
                    end
                end
            end
            PARSE_PAYLOAD: begin
                bytes_left = bytes_left - 32'd1;
                last       = (bytes_left == 32'd0);
                if (last) parse_state = PARSE_HEADER;
                if (verdict == ST_DATA_OK) begin
                    push_frame_result(KIND_PAYLOAD, b, last);
                end else if (last) begin
                    push_frame_result(KIND_FRAME_END, 8'd0, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // Compare one accepted result transaction with the oldest prediction
    task automatic check_result();
        t_out_item exp;
        if (expected_q.size() == 0) begin
            report("result with none pending, kind", {30'd0, out_ch.kind}, '0);
        end else begin
            exp = expected_q.pop_front();
            if (out_ch.kind !== exp.kind)
                report("kind", {30'd0, out_ch.kind}, {30'd0, exp.kind});
            if (out_ch.stream_id !== exp.stream_id)
                report("stream_id", {16'd0, out_ch.stream_id}, {16'd0, exp.stream_id});
            if (out_ch.payload_byte !== exp.payload_byte)
                report("payload_byte", {24'd0, out_ch.payload_byte}, {24'd0, exp.payload_byte});
            if (out_ch.frame_last !== exp.frame_last)
                report("frame_last", {31'd0, out_ch.frame_last}, {31'd0, exp.frame_last});
            if (out_ch.status !== exp.status)
                report("status", {29'd0, out_ch.status}, {29'd0, exp.status});
            if (out_ch.seq_number !== exp.seq_number)
                report("seq_number", out_ch.seq_number, exp.seq_number);
            if (out_ch.eof_total !== exp.eof_total)
                report("eof_total", {16'd0, out_ch.eof_total}, {16'd0, exp.eof_total});
        end
    endtask

    // Sample all three channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state   = PARSE_HEADER;
            hdr_fill      = 0;
            crc_acc       = CRC_ONES;
            bytes_left    = '0;
            verdict       = ST_DATA_OK;
            magic_reg     = MAGIC_WORD_RST;
            seq_limit_reg = SEQ_LIMIT_RST;
            max_len_reg   = MAX_PAYLOAD_RST;
            for (int k = 0; k < HEADER_BYTES; k++) hdr_bytes[k] = '0;
            for (int s = 0; s < STREAMS; s++) begin
                seq_tab[s] = '0;
                eof_tab[s] = '0;
            end
            expected_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_MAGIC_WORD:  magic_reg     = cfg_ch.data;
                    CFG_SEQ_LIMIT:   seq_limit_reg = cfg_ch.data;
                    CFG_MAX_PAYLOAD: max_len_reg   = cfg_ch.data[15:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) take_byte(in_ch.data_byte);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

    initial fail_count = 0;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - top level of the stream deframer bench
// Builds frames byte by byte (directed corner frames, then random frames
// under several register settings), drives them with random gaps, throttles
// the result side, and gives the verdict from the checker's mismatch count.
// ============================================================================
module testbench;
    import msdf_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          sent_bytes;
    int          stall_cycles;
    bit          in_idle;
    bit          out_idle;
    bit          hold_req;
    logic [31:0] cur_magic;
    logic [15:0] cur_max;

    msdf_byte_if   in_ch ();
    msdf_result_if out_ch ();
    msdf_cfg_if    cfg_ch ();

    muxed_stream_deframer_crc32_header_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    msdf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: too long without any transaction ends the run
    initial stall_cycles = 0;
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // One link byte transaction, after a random gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = in_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_bytes++;
    endtask

    // Header plus payload; crc_flip corrupts the header CRC
    task automatic send_frame(input logic [31:0] magic, input logic [15:0] sid,
                              input logic [7:0] ftype, input logic [31:0] plen,
                              input logic [31:0] crc_flip);
        logic [7:0]  hdr [HEADER_BYTES];
        logic [31:0] crc;
        int          k;
        {hdr[0], hdr[1], hdr[2], hdr[3]} = magic;
        {hdr[4], hdr[5], hdr[6], hdr[7]} = plen;
        {hdr[8], hdr[9]}                 = sid;
        hdr[10] = ftype;
        hdr[11] = 8'($urandom_range(0, 255));
        crc = CRC_ONES;
        for (k = 0; k < CRC_SPAN; k++) crc = crc32_byte(crc, hdr[k]);
        crc = crc ^ CRC_ONES ^ crc_flip;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = crc;
        for (k = 0; k < HEADER_BYTES; k++) send_byte(hdr[k]);
        for (k = 0; k < plen; k++) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) in_idle = !in_idle;
    endtask

    task automatic good_frame(input logic [15:0] sid, input logic [7:0] ftype,
                              input logic [31:0] plen);
        send_frame(cur_magic, sid, ftype, plen, 32'd0);
    endtask

    // Stop driving and wait until every predicted result is out
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // All three registers, back to back; junk in the unused upper bits
    task automatic set_config(input logic [31:0] magic, input logic [31:0] limit,
                              input logic [15:0] max_len);
        write_reg(CFG_MAGIC_WORD, magic);
        write_reg(CFG_SEQ_LIMIT, limit);
        write_reg(CFG_MAX_PAYLOAD, {16'($urandom_range(0, 65535)), max_len});
        cfg_ch.valid <= 1'b0;
        cur_magic = magic;
        cur_max   = max_len;
    endtask

    // Mostly well-formed frames on valid streams, with some bad ids,
    // unknown types, oversize lengths and corrupted CRCs mixed in
    task automatic random_frames(input int target);
        logic [15:0] sid;
        logic [7:0]  ftype;
        logic [31:0] plen;
        logic [31:0] flip;
        int          pick;
        while (sent_bytes < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) sid = 16'($urandom_range(0, STREAM_COUNT_DEF - 1));
            else if (pick < 93) sid = 16'($urandom_range(STREAM_COUNT_DEF, 15));
            else sid = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 55) ftype = TYPE_DATA;
            else if (pick < 85) ftype = TYPE_EOF;
            else ftype = 8'($urandom_range(2, 255));
            pick = $urandom_range(0, 99);
            if (pick < 10) plen = $urandom_range(13, 40);
            else if (pick < 20 && cur_max < 40) plen = {16'd0, cur_max} + 32'd1;
            else plen = $urandom_range(0, 12);
            flip = ($urandom_range(0, 99) < 8) ? (32'd1 << $urandom_range(0, 31)) : 32'd0;
            send_frame(cur_magic, sid, ftype, plen, flip);
        end
    endtask

    // Result side: random ready gaps, plus a long hold-off on request
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        out_idle = 1'b1;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = out_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            if ($urandom_range(0, 63) == 0) out_idle = !out_idle;
        end
    end

    // Stimulus and verdict
    initial begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_MAGIC_WORD;
        cfg_ch.data     <= '0;
        in_idle    = 1'b1;
        hold_req   = 1'b0;
        sent_bytes = 0;
        cur_magic  = MAGIC_WORD_RST;
        cur_max    = MAX_PAYLOAD_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: corner frames
        good_frame(16'd0, TYPE_DATA, 32'd0);       // result on last header byte
        good_frame(16'd1, TYPE_DATA, 32'd3);
        good_frame(16'd1, TYPE_EOF, 32'd0);
        good_frame(16'd2, TYPE_EOF, 32'd2);        // eof payload skipped
        send_frame(cur_magic, 16'd3, TYPE_DATA, 32'd2, 32'h8000_0000);
        good_frame(16'd4, TYPE_DATA, 32'd2);       // first id out of range
        good_frame(16'hFFFF, TYPE_EOF, 32'd0);
        good_frame(16'd1, 8'd7, 32'd1);            // unknown type
        good_frame(16'd3, 8'hFF, 32'd0);
        good_frame(16'd3, TYPE_DATA, 32'd1);
        settle();

        // Tight limits: oversize, sequence overflow and their precedence
        set_config($urandom, 32'd2, 16'd4);
        good_frame(16'd0, TYPE_DATA, 32'd5);
        good_frame(16'd2, TYPE_DATA, 32'd4);
        good_frame(16'd2, TYPE_DATA, 32'd1);
        good_frame(16'd2, TYPE_DATA, 32'd2);
        good_frame(16'd2, TYPE_DATA, 32'd9);
        good_frame(16'd2, TYPE_EOF, 32'd3);
        good_frame(16'd0, TYPE_DATA, 32'd4);
        random_frames(450);
        settle();

        // Everything at zero
        set_config(32'd0, 32'd0, 16'd0);
        random_frames(800);
        settle();

        // Everything at its maximum; result side stalls for a while
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        hold_req = 1'b1;
        random_frames(1150);
        settle();

        // Reset magic word written back, sequence limit 30, small payload limit
        set_config(MAGIC_WORD_RST, 32'd30, 16'd12);
        hold_req = 1'b1;
        random_frames(1500);
        settle();

        set_config($urandom, $urandom_range(5, 60), 16'($urandom_range(1, 20)));
        random_frames(1810);
        settle();

        // Wrong start word halts the block; later bytes are dropped
        send_frame(cur_magic ^ (32'd1 << $urandom_range(0, 31)),
                   16'($urandom_range(0, 65535)), TYPE_DATA, 32'd0, 32'd0);
        repeat (20) send_byte(8'($urandom_range(0, 255)));
        settle();
        repeat (20) @(posedge clk);

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
